>>> design/hvcp_pkg.sv
package hvcp_pkg;

	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 10;
	localparam int SUM_W   = 12;
	localparam int BYTE_W  = 8;
	localparam int PHASE_W = 3;
	localparam int CNT_W   = 2;

	localparam logic [PHASE_W-1:0] PH_ADDR   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_VAL_HI = 3'd1;
	localparam logic [PHASE_W-1:0] PH_VAL_LO = 3'd2;
	localparam logic [PHASE_W-1:0] PH_END    = 3'd3;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CNT_W-1:0] MAX_ADDR_DIGITS = 2'd3;
	localparam logic [3:0] LEAD_MIN = 4'd1;
	localparam logic [3:0] LEAD_MAX = 4'd3;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_digit_t d;
		d.is_hex = 1'b1;
		d.val    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			d.val = c[3:0] + 4'd9;
		end else begin
			d.is_hex = 1'b0;
		end
		return d;
	endfunction

endpackage

>>> design/hex_address_value_command_parser.sv
// Hex address/value command parser.
// Input channel: in_valid / in_stall / char_code, one ASCII character per
// request. A command is 1..3 hex address digits, a space, two hex value
// digits and a NUL; a 3-digit address must lead with 1, 2 or 3.
// Output channel: out_valid / out_stall / accepted / address / data_byte,
// one request per NUL. address and data_byte are zero unless accepted.
// The result is registered and appears in the cycle after the NUL is taken.
// Throughput: one character per cycle; the parse state is a few registers
// updated by a small decode in the same cycle the character is taken.
// While a result waits under out_stall, non-NUL characters are still
// taken; only a NUL is held off (in_stall) until the output register frees.
// Reset (arst_n low) clears the parse state and drops out_valid; the next
// character starts a new command. Every NUL clears the parse state.
module hex_address_value_command_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hvcp_pkg::CHAR_W-1:0]     char_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            accepted,
	output logic [hvcp_pkg::ADDR_W-1:0]     address,
	output logic [hvcp_pkg::BYTE_W-1:0]     data_byte
);

	logic [hvcp_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [hvcp_pkg::SUM_W-1:0]   addr_sum_q, addr_sum_d;
	logic [hvcp_pkg::CNT_W-1:0]   digits_q, digits_d;
	logic [hvcp_pkg::BYTE_W-1:0]  byte_sum_q, byte_sum_d;
	logic                         broken_q, broken_d;
	logic                         out_valid_q;
	logic                         take;
	logic                         is_nul;
	logic                         ok;
	hvcp_pkg::hex_digit_t         dig;

	assign is_nul   = (char_code == hvcp_pkg::CH_NUL);
	assign in_stall = out_valid_q && out_stall && is_nul;
	assign take     = in_valid && !in_stall;
	assign dig      = hvcp_pkg::hex_decode(char_code);
	assign ok       = !broken_q && (phase_q == hvcp_pkg::PH_END);
	assign out_valid = out_valid_q;

	always_comb begin
		phase_d    = phase_q;
		addr_sum_d = addr_sum_q;
		digits_d   = digits_q;
		byte_sum_d = byte_sum_q;
		broken_d   = broken_q;
		if (is_nul) begin
			phase_d    = hvcp_pkg::PH_ADDR;
			addr_sum_d = '0;
			digits_d   = '0;
			byte_sum_d = '0;
			broken_d   = 1'b0;
		end else if (!broken_q) begin
			unique case (phase_q)
				hvcp_pkg::PH_ADDR: begin
					if (dig.is_hex) begin
						if (digits_q == hvcp_pkg::MAX_ADDR_DIGITS) begin
							broken_d = 1'b1;
						end else begin
							// third digit: the one now shifting to the top must be 1..3
							if (digits_q == 2'd2 && (addr_sum_q[7:4] < hvcp_pkg::LEAD_MIN ||
									addr_sum_q[7:4] > hvcp_pkg::LEAD_MAX)) begin
								broken_d = 1'b1;
							end
							addr_sum_d = {addr_sum_q[hvcp_pkg::SUM_W-5:0], dig.val};
							digits_d   = digits_q + 2'd1;
						end
					end else if (char_code == hvcp_pkg::CH_SPACE && digits_q != 2'd0) begin
						phase_d = hvcp_pkg::PH_VAL_HI;
					end else begin
						broken_d = 1'b1;
					end
				end
				hvcp_pkg::PH_VAL_HI: begin
					if (dig.is_hex) begin
						byte_sum_d = {dig.val, 4'd0};
						phase_d    = hvcp_pkg::PH_VAL_LO;
					end else begin
						broken_d = 1'b1;
					end
				end
				hvcp_pkg::PH_VAL_LO: begin
					if (dig.is_hex) begin
						byte_sum_d = {byte_sum_q[7:4], dig.val};
						phase_d    = hvcp_pkg::PH_END;
					end else begin
						broken_d = 1'b1;
					end
				end
				default: begin
					broken_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= hvcp_pkg::PH_ADDR;
			addr_sum_q <= '0;
			digits_q   <= '0;
			byte_sum_q <= '0;
			broken_q   <= 1'b0;
		end else if (take) begin
			phase_q    <= phase_d;
			addr_sum_q <= addr_sum_d;
			digits_q   <= digits_d;
			byte_sum_q <= byte_sum_d;
			broken_q   <= broken_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && is_nul) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only when a NUL is taken
	always_ff @(posedge clk) begin
		if (take && is_nul) begin
			accepted  <= ok;
			address   <= ok ? addr_sum_q[hvcp_pkg::ADDR_W-1:0] : '0;
			data_byte <= ok ? byte_sum_q : '0;
		end
	end

	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_nul) |=> (out_valid && phase_q == hvcp_pkg::PH_ADDR && digits_q == 2'd0
			&& !broken_q))
		else $error("NUL did not produce a result and clear the parse state");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (address == '0 && data_byte == '0))
		else $error("rejected command carries nonzero payload");

	a_addr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(digits_q == 2'd0) |-> (phase_q == hvcp_pkg::PH_ADDR))
		else $error("value phase reached without any address digit");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule
